// ===== src/lzrd_pkg.sv =====
// Shared types and constants for the LZSS ring-dictionary decoder.
package lzrd_pkg;

    localparam int DICT_SIZE = 4096;
    localparam int RING_AW   = $clog2(DICT_SIZE);
    localparam int CFG_AW    = 2;
    localparam int CFG_DW    = 32;
    localparam int CNT_W     = 32;
    localparam int LEN_W     = 5;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] REG_DICT_START = 2'd0;
    localparam logic [CFG_AW-1:0] REG_MIN_MATCH  = 2'd1;
    localparam logic [CFG_AW-1:0] REG_OUT_LIMIT  = 2'd2;

    // Register values after reset
    localparam logic [RING_AW-1:0] DICT_START_RST = 12'd4078;
    localparam logic [3:0]         MIN_MATCH_RST  = 4'd3;
    localparam logic [CNT_W-1:0]   OUT_LIMIT_RST  = 32'hFFFF_FFFF;

    localparam logic [3:0] FLAGS_PER_BYTE = 4'd8;

    // Sequencer states
    typedef enum logic [4:0] {
        S_CLR  = 5'b00001,
        S_IDLE = 5'b00010,
        S_LIT  = 5'b00100,
        S_RD   = 5'b01000,
        S_WR   = 5'b10000
    } t_state;

    // Ring memory access request
    typedef struct packed {
        logic               rd_en;
        logic [RING_AW-1:0] rd_addr;
        logic               wr_en;
        logic [RING_AW-1:0] wr_addr;
        logic [7:0]         wr_data;
    } t_ring_req;

endpackage

// ===== src/lzss_ring_decoder.sv =====
// LZSS decoder with a 4096-byte ring dictionary and a stream interface.
//
// Channel   | Direction | Data                  | Sideband
// s_axis    | in        | tdata[7:0] in_byte    | tlast last_in
// m_axis    | out       | tdata[7:0] out_byte   | tlast run_last, tuser limit_hit
// i_cfg     | in        | i_cfg_data register   | i_cfg_idx register index
//
// A flag byte or a match low byte is taken in the idle state; a literal then
// passes through the literal state, and a match reads the ring, then writes it
// back and emits, for each copied byte, since every copied byte goes through
// the single ring read port. After reset a clearing pass writes zeros over all
// 4096 ring entries, one a cycle; no input is accepted until it is done.
// A stalled output holds its byte; the sequencer waits until it is taken.
module lzss_ring_decoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lzrd_pkg::CFG_AW-1:0] i_cfg_idx,
    input  logic [lzrd_pkg::CFG_DW-1:0] i_cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,  // [7:0] in_byte
    input  logic                        s_axis_tlast,  // last_in
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,  // [7:0] out_byte
    output logic                        m_axis_tlast,  // run_last
    output logic                        m_axis_tuser   // [0] limit_hit
);

    localparam int AW = lzrd_pkg::RING_AW;
    localparam int CW = lzrd_pkg::CNT_W;
    localparam int LW = lzrd_pkg::LEN_W;

    lzrd_pkg::t_state r_state, n_state;

    logic [3:0]    r_min_match;
    logic [CW-1:0] r_out_limit;

    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_clr, n_clr;
    logic [7:0]    r_flags, n_flags;
    logic [3:0]    r_flags_left, n_flags_left;
    logic [7:0]    r_match_low, n_match_low;
    logic          r_expect_high, n_expect_high;
    logic [CW-1:0] r_count, n_count;
    logic          r_stopped, n_stopped;
    logic [AW-1:0] r_src, n_src;
    logic [LW-1:0] r_left, n_left;
    logic [7:0]    r_lit, n_lit;

    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_data, n_out_data;
    logic          r_out_last, n_out_last;
    logic          r_out_hit, n_out_hit;

    lzrd_pkg::t_ring_req ring_req;
    logic [7:0]          ring_rd_data;

    logic          in_acc;
    logic          out_free;
    logic          emit_en;
    logic [7:0]    emit_byte;
    logic          emit_last;
    logic [CW-1:0] count_inc;
    logic          emit_hit;
    logic [LW-1:0] match_len;
    logic [CW-1:0] room;
    logic [LW-1:0] match_eff;

    lzrd_ring u_ring (
        .i_clk     (i_clk),
        .i_req     (ring_req),
        .o_rd_data (ring_rd_data)
    );

    assign s_axis_tready = (r_state == lzrd_pkg::S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    // Match length and room left before the output limit
    assign match_len = {1'b0, s_axis_tdata[3:0]} + {1'b0, r_min_match};
    assign room      = r_out_limit - r_count;
    assign match_eff = (room < {{(CW-LW){1'b0}}, match_len}) ? room[LW-1:0] : match_len;

    // Emission of one decoded byte
    assign count_inc = r_count + {{(CW-1){1'b0}}, 1'b1};
    assign emit_hit  = (count_inc == r_out_limit);
    always_comb begin
        emit_en   = 1'b0;
        emit_byte = r_lit;
        emit_last = 1'b1;
        case (r_state)
            lzrd_pkg::S_LIT: begin
                emit_en = out_free;
            end
            lzrd_pkg::S_WR: begin
                emit_en   = out_free;
                emit_byte = ring_rd_data;
                emit_last = (r_left == {{(LW-1){1'b0}}, 1'b1});
            end
            default: begin
                emit_en = 1'b0;
            end
        endcase
    end

    // Ring access: clearing pass, copy reads, emitted-byte writes
    always_comb begin
        ring_req.rd_en   = (r_state == lzrd_pkg::S_RD);
        ring_req.rd_addr = r_src;
        ring_req.wr_en   = emit_en || (r_state == lzrd_pkg::S_CLR);
        ring_req.wr_addr = (r_state == lzrd_pkg::S_CLR) ? r_clr : r_wr;
        ring_req.wr_data = (r_state == lzrd_pkg::S_CLR) ? 8'd0 : emit_byte;
    end

    // Sequencer next state
    always_comb begin
        n_state       = r_state;
        n_wr          = r_wr;
        n_clr         = r_clr;
        n_flags       = r_flags;
        n_flags_left  = r_flags_left;
        n_match_low   = r_match_low;
        n_expect_high = r_expect_high;
        n_count       = r_count;
        n_stopped     = r_stopped;
        n_src         = r_src;
        n_left        = r_left;
        n_lit         = r_lit;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_data    = r_out_data;
        n_out_last    = r_out_last;
        n_out_hit     = r_out_hit;

        case (r_state)
            lzrd_pkg::S_CLR: begin
                n_clr = r_clr + {{(AW-1){1'b0}}, 1'b1};
                if (r_clr == {AW{1'b1}}) begin
                    n_state = lzrd_pkg::S_IDLE;
                end
            end
            lzrd_pkg::S_IDLE: begin
                if (in_acc && !r_stopped) begin
                    if (r_count >= r_out_limit) begin
                        n_stopped = 1'b1;
                    end else begin
                        if (r_flags_left == 4'd0) begin
                            n_flags      = s_axis_tdata;
                            n_flags_left = lzrd_pkg::FLAGS_PER_BYTE;
                        end else if (r_flags[0]) begin
                            n_lit        = s_axis_tdata;
                            n_flags      = {1'b0, r_flags[7:1]};
                            n_flags_left = r_flags_left - 4'd1;
                            n_state      = lzrd_pkg::S_LIT;
                        end else if (!r_expect_high) begin
                            n_match_low   = s_axis_tdata;
                            n_expect_high = 1'b1;
                        end else begin
                            n_src         = {r_match_low, s_axis_tdata[7:4]};
                            n_left        = match_eff;
                            n_expect_high = 1'b0;
                            n_flags       = {1'b0, r_flags[7:1]};
                            n_flags_left  = r_flags_left - 4'd1;
                            if (match_eff != {LW{1'b0}}) begin
                                n_state = lzrd_pkg::S_RD;
                            end
                        end
                        if (s_axis_tlast) begin
                            n_stopped = 1'b1;
                        end
                    end
                end
            end
            lzrd_pkg::S_LIT: begin
                if (emit_en) begin
                    n_state = lzrd_pkg::S_IDLE;
                end
            end
            lzrd_pkg::S_RD: begin
                n_state = lzrd_pkg::S_WR;
            end
            lzrd_pkg::S_WR: begin
                if (emit_en) begin
                    n_src  = r_src + {{(AW-1){1'b0}}, 1'b1};
                    n_left = r_left - {{(LW-1){1'b0}}, 1'b1};
                    n_state = emit_last ? lzrd_pkg::S_IDLE : lzrd_pkg::S_RD;
                end
            end
            default: begin
                n_state = lzrd_pkg::S_IDLE;
            end
        endcase

        // Count, write back and present an emitted byte
        if (emit_en) begin
            n_wr        = r_wr + {{(AW-1){1'b0}}, 1'b1};
            n_count     = count_inc;
            n_out_valid = 1'b1;
            n_out_data  = emit_byte;
            n_out_last  = emit_last;
            n_out_hit   = emit_hit;
            if (emit_hit) begin
                n_stopped = 1'b1;
            end
        end

        // A new start position reloads the write pointer at once
        if (i_cfg_we && (i_cfg_idx == lzrd_pkg::REG_DICT_START)) begin
            n_wr = i_cfg_data[AW-1:0];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= lzrd_pkg::S_CLR;
            r_wr          <= lzrd_pkg::DICT_START_RST;
            r_clr         <= '0;
            r_flags       <= '0;
            r_flags_left  <= '0;
            r_match_low   <= '0;
            r_expect_high <= 1'b0;
            r_count       <= '0;
            r_stopped     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_wr          <= n_wr;
            r_clr         <= n_clr;
            r_flags       <= n_flags;
            r_flags_left  <= n_flags_left;
            r_match_low   <= n_match_low;
            r_expect_high <= n_expect_high;
            r_count       <= n_count;
            r_stopped     <= n_stopped;
            r_out_valid   <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_src      <= n_src;
        r_left     <= n_left;
        r_lit      <= n_lit;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
        r_out_hit  <= n_out_hit;
    end

    // Configuration registers; the start position only loads the write pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_match  <= lzrd_pkg::MIN_MATCH_RST;
            r_out_limit  <= lzrd_pkg::OUT_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lzrd_pkg::REG_MIN_MATCH:  r_min_match  <= i_cfg_data[3:0];
                lzrd_pkg::REG_OUT_LIMIT:  r_out_limit  <= i_cfg_data[CW-1:0];
                default: begin
                    r_min_match <= r_min_match;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_hit;

endmodule

// ===== src/lzrd_ring.sv =====
// Ring dictionary memory: one write and one registered read per cycle.
module lzrd_ring (
    input  logic                i_clk,
    input  lzrd_pkg::t_ring_req i_req,
    output logic [7:0]          o_rd_data
);

    logic [7:0] r_mem [lzrd_pkg::DICT_SIZE];
    logic [7:0] r_rd_data;

    // Write and read the array
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/lzrd_check.sv =====
// Port-level checks for the LZSS ring decoder, bound to the top level.
module lzrd_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       m_axis_tuser
);

    // Hold a stalled output request
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output request changed while stalled");

    // The byte that reaches the limit ends its run
    a_hit_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("limit byte without run end");

    // Nothing follows the limit byte
    a_hit_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser |=> !m_axis_tvalid)
        else $error("output after limit reached");

    // Drop output and refuse input straight after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !s_axis_tready)
        else $error("activity right after reset");

endmodule

bind lzss_ring_decoder lzrd_check u_lzrd_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
